// ----- sv/atcs_pkg.sv -----
// Shared types and constants of the AT command host sequencer.
// Used by atcs_ctrl, atcs_dp and at_command_host_sequencer.
`timescale 1ns / 1ps
package atcs_pkg;

  localparam int unsigned MaxResults = 10;
  localparam int unsigned ResCntW    = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [15:0] BusyRetryRst   = 16'd100;
  localparam logic [15:0] ResetPeriodRst = 16'd10000;
  localparam logic [7:0]  ErrorLimitRst  = 8'd10;
  localparam logic [15:0] BuiltinTmoRst  = 16'd200;
  localparam logic [15:0] TimerMax       = 16'hFFFF;
  localparam logic [7:0]  TallyMax       = 8'hFF;
  localparam logic [1:0]  BuiltinLast    = 2'd2;

  typedef enum logic [3:0] {
    OP_TICK   = 4'd0,
    OP_SUBMIT = 4'd1,
    OP_OK     = 4'd2,
    OP_ERROR  = 4'd3,
    OP_PROMPT = 4'd4,
    OP_BUSY   = 4'd5,
    OP_READY  = 4'd6,
    OP_REPORT = 4'd7,
    OP_INIT   = 4'd8
  } op_e;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_SEND_CMD  = 4'd1,
    ACT_SEND_DATA = 4'd2,
    ACT_SEND_RST  = 4'd3,
    ACT_SEND_ESC  = 4'd4,
    ACT_COMPLETE  = 4'd5,
    ACT_FORWARD   = 4'd6,
    ACT_ACCEPTED  = 4'd7,
    ACT_REJECTED  = 4'd8
  } act_e;

  typedef enum logic [1:0] {
    DONE_OK      = 2'd0,
    DONE_ERROR   = 2'd1,
    DONE_TIMEOUT = 2'd2
  } done_e;

  typedef enum logic [2:0] {
    MD_IDLE        = 3'd0,
    MD_WAIT_RSP    = 3'd1,
    MD_WAIT_PROMPT = 3'd2,
    MD_NOT_READY   = 3'd3,
    MD_BUSY        = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUSY_RETRY   = 2'd0,
    CFG_RESET_PERIOD = 2'd1,
    CFG_ERROR_LIMIT  = 2'd2,
    CFG_BUILTIN_TMO  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_FLUSH,
    SQ_RESET,
    SQ_LOAD,
    SQ_DISPATCH,
    SQ_DONE
  } seq_state_e;

  typedef struct packed {
    logic [3:0]  operation;
    logic [7:0]  cmd_id;
    logic        cmd_has_data;
    logic        cmd_has_parser;
    logic [15:0] cmd_timeout_ms;
  } in_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] result_cmd_id;
    logic [1:0] completion;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [15:0] timeout;
    logic        parser;
    logic        data;
    logic [7:0]  id;
  } entry_t;

  // one-hot commands from the sequencer to the datapath
  typedef struct packed {
    logic take_item;
    logic exec;
    logic flush_step;
    logic rst_step;
    logic load_step;
    logic dispatch;
    logic finish;
  } seq_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_init;
    logic mode_idle;
    logic tally_over;
    logic queue_nz;
    logic load_last;
    logic emit_ok;
    logic fin_ok;
  } seq_stat_t;

endpackage

// ----- sv/atcs_ctrl.sv -----
// Sequencing state machine of the AT command host sequencer.
// Depends on atcs_pkg; drives atcs_dp through seq_cmd_t.
`timescale 1ns / 1ps
module atcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  atcs_pkg::seq_stat_t stat_i,
  output atcs_pkg::seq_cmd_t  cmd_o
);
  import atcs_pkg::*;

  seq_state_e state_q, state_d;
  logic       from_tick_q, from_tick_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      from_tick_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      from_tick_q <= from_tick_d;
    end
  end

  // next state
  always_comb begin
    state_d     = state_q;
    from_tick_d = from_tick_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (in_valid_i) state_d = SQ_EXEC;
      end
      SQ_EXEC: begin
        if ((stat_i.is_tick && stat_i.mode_idle && stat_i.tally_over) || stat_i.is_init) begin
          state_d     = SQ_FLUSH;
          from_tick_d = stat_i.is_tick;
        end else if (stat_i.is_tick && stat_i.mode_idle && stat_i.queue_nz) begin
          state_d = SQ_DISPATCH;
        end else begin
          state_d = SQ_DONE;
        end
      end
      SQ_FLUSH: begin
        if (!stat_i.queue_nz) state_d = SQ_RESET;
      end
      SQ_RESET: begin
        if (stat_i.emit_ok) state_d = SQ_LOAD;
      end
      SQ_LOAD: begin
        if (stat_i.load_last) state_d = from_tick_q ? SQ_DISPATCH : SQ_DONE;
      end
      SQ_DISPATCH: begin
        if (stat_i.emit_ok) state_d = SQ_DONE;
      end
      SQ_DONE: begin
        if (stat_i.fin_ok) state_d = SQ_IDLE;
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SQ_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_item = in_valid_i;
      end
      SQ_EXEC:     cmd_o.exec       = 1'b1;
      SQ_FLUSH:    cmd_o.flush_step = stat_i.queue_nz && stat_i.emit_ok;
      SQ_RESET:    cmd_o.rst_step   = stat_i.emit_ok;
      SQ_LOAD:     cmd_o.load_step  = 1'b1;
      SQ_DISPATCH: cmd_o.dispatch   = stat_i.emit_ok;
      SQ_DONE:     cmd_o.finish     = stat_i.fin_ok;
      default: ;
    endcase
  end

endmodule

// ----- sv/atcs_dp.sv -----
// Datapath of the AT command host sequencer: queue memory, current command,
// timers, error tally, config registers and result staging. Depends on atcs_pkg.
`timescale 1ns / 1ps
module atcs_dp #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  atcs_pkg::in_t                   in_data_i,
  input  logic                            cfg_valid_i,
  input  logic [atcs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [atcs_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output atcs_pkg::out_t                  out_data_o,
  input  atcs_pkg::seq_cmd_t              cmd_i,
  output atcs_pkg::seq_stat_t             stat_o
);
  import atcs_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  logic [15:0] busy_retry_q, reset_period_q, builtin_tmo_q;
  logic [7:0]  error_limit_q;

  in_t         item_q, item_d;
  mode_e       mode_q, mode_d, saved_q, saved_d;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  entry_t      cur_q, cur_d;
  logic        cur_valid_q, cur_valid_d;
  logic [15:0] send_q, send_d, wait_q, wait_d, send_inc, wait_inc;
  logic [7:0]  tally_q, tally_d, tally_inc;
  logic [1:0]  load_cnt_q, load_cnt_d;

  entry_t      mem [QUEUE_DEPTH];
  entry_t      rd_q, mem_wd;
  logic        mem_we;

  logic        emit_v, emit_go, cap;
  out_t        emit_r;
  out_t        hold_q, out_q;
  logic        hold_v_q, out_v_q;
  logic [ResCntW-1:0] res_cnt_q;
  op_e         op;

  assign op        = op_e'(item_q.operation);
  assign send_inc  = (send_q == TimerMax) ? send_q : send_q + 16'd1;
  assign wait_inc  = (wait_q == TimerMax) ? wait_q : wait_q + 16'd1;
  assign tally_inc = (tally_q == TallyMax) ? tally_q : tally_q + 8'd1;

  always_comb begin
    item_d      = item_q;
    mode_d      = mode_q;
    saved_d     = saved_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    send_d      = send_q;
    wait_d      = wait_q;
    tally_d     = tally_q;
    load_cnt_d  = load_cnt_q;
    mem_we      = 1'b0;
    mem_wd      = '{timeout: item_q.cmd_timeout_ms, parser: item_q.cmd_has_parser,
                    data: item_q.cmd_has_data, id: item_q.cmd_id};
    emit_v      = 1'b0;
    emit_r      = '0;

    if (cmd_i.take_item) item_d = in_data_i;

    if (cmd_i.exec) begin
      case (op)
        OP_TICK: begin
          send_d = send_inc;
          wait_d = wait_inc;
          case (mode_q)
            MD_BUSY: begin
              if (wait_inc > busy_retry_q && cur_valid_q) begin
                mode_d = cur_q.data ? MD_WAIT_PROMPT : saved_q;
                emit_v = 1'b1;
                emit_r = '{action: ACT_SEND_CMD, result_cmd_id: cur_q.id,
                           completion: DONE_OK, last: 1'b0};
              end
            end
            MD_WAIT_RSP, MD_WAIT_PROMPT: begin
              if (!cur_valid_q) begin
                mode_d = MD_IDLE;
              end else if (send_inc > cur_q.timeout) begin
                emit_v      = 1'b1;
                emit_r      = '{action: ACT_COMPLETE, result_cmd_id: cur_q.id,
                                completion: DONE_TIMEOUT, last: 1'b0};
                cur_valid_d = 1'b0;
                mode_d      = MD_IDLE;
              end
            end
            MD_NOT_READY: begin
              if (wait_inc > reset_period_q) begin
                emit_v = 1'b1;
                emit_r = '{action: ACT_SEND_RST, result_cmd_id: 8'd0,
                           completion: DONE_OK, last: 1'b0};
                wait_d = '0;
              end
            end
            default: ;  // idle: the sequencer runs dispatch or reinit
          endcase
        end
        OP_SUBMIT: begin
          emit_v = 1'b1;
          emit_r = '{action: ACT_REJECTED, result_cmd_id: item_q.cmd_id,
                     completion: DONE_OK, last: 1'b0};
          if (count_q < CntFull) begin
            emit_r.action = ACT_ACCEPTED;
            mem_we        = 1'b1;
            tail_d        = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
            count_d       = count_q + 1'b1;
          end
        end
        OP_OK, OP_ERROR: begin
          if (mode_q == MD_WAIT_RSP) begin
            emit_v      = cur_valid_q;
            emit_r      = '{action: ACT_COMPLETE, result_cmd_id: cur_q.id,
                            completion: (op == OP_OK) ? DONE_OK : DONE_ERROR,
                            last: 1'b0};
            cur_valid_d = 1'b0;
            mode_d      = MD_IDLE;
            if (op == OP_ERROR) tally_d = tally_inc;
          end
        end
        OP_PROMPT: begin
          emit_v = 1'b1;
          if (mode_q == MD_WAIT_PROMPT && cur_valid_q && cur_q.data) begin
            emit_r = '{action: ACT_SEND_DATA, result_cmd_id: cur_q.id,
                       completion: DONE_OK, last: 1'b0};
            mode_d = MD_WAIT_RSP;
          end else begin
            emit_r  = '{action: ACT_SEND_ESC,
                        result_cmd_id: cur_valid_q ? cur_q.id : 8'd0,
                        completion: DONE_OK, last: 1'b0};
            tally_d = tally_inc;
          end
        end
        OP_BUSY: begin
          if (cur_valid_q) begin
            saved_d = mode_q;
            mode_d  = MD_BUSY;
            wait_d  = '0;
          end
        end
        OP_READY: mode_d = MD_IDLE;
        OP_REPORT: begin
          emit_v = cur_valid_q && cur_q.parser;
          emit_r = '{action: ACT_FORWARD, result_cmd_id: cur_q.id,
                     completion: DONE_OK, last: 1'b0};
        end
        default: ;  // init is sequenced; unknown codes do nothing
      endcase
    end

    if (cmd_i.flush_step) begin
      emit_v  = 1'b1;
      emit_r  = '{action: ACT_COMPLETE, result_cmd_id: rd_q.id,
                  completion: DONE_ERROR, last: 1'b0};
      head_d  = (head_q == PtrLast) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end

    if (cmd_i.rst_step) begin
      emit_v      = 1'b1;
      emit_r      = '{action: ACT_SEND_RST, result_cmd_id: 8'd0,
                      completion: DONE_OK, last: 1'b0};
      mode_d      = MD_NOT_READY;
      head_d      = '0;
      tail_d      = '0;
      count_d     = '0;
      cur_valid_d = 1'b0;
      tally_d     = '0;
      wait_d      = '0;
      load_cnt_d  = '0;
    end

    // built-in commands: AT test, echo off, auto-connect off
    if (cmd_i.load_step) begin
      mem_we     = 1'b1;
      mem_wd     = '{timeout: builtin_tmo_q, parser: 1'b0, data: 1'b0,
                     id: 8'(load_cnt_q)};
      tail_d     = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
      count_d    = count_q + 1'b1;
      load_cnt_d = load_cnt_q + 2'd1;
    end

    if (cmd_i.dispatch) begin
      emit_v      = 1'b1;
      emit_r      = '{action: ACT_SEND_CMD, result_cmd_id: rd_q.id,
                      completion: DONE_OK, last: 1'b0};
      cur_d       = rd_q;
      cur_valid_d = 1'b1;
      send_d      = '0;
      head_d      = (head_q == PtrLast) ? '0 : head_q + 1'b1;
      count_d     = count_q - 1'b1;
      if (rd_q.data) begin
        mode_d = MD_WAIT_PROMPT;
        wait_d = '0;
      end else begin
        mode_d = MD_WAIT_RSP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_retry_q   <= BusyRetryRst;
      reset_period_q <= ResetPeriodRst;
      error_limit_q  <= ErrorLimitRst;
      builtin_tmo_q  <= BuiltinTmoRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BUSY_RETRY:   busy_retry_q   <= cfg_data_i;
        CFG_RESET_PERIOD: reset_period_q <= cfg_data_i;
        CFG_ERROR_LIMIT:  error_limit_q  <= cfg_data_i[7:0];
        CFG_BUILTIN_TMO:  builtin_tmo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MD_NOT_READY;
      saved_q     <= MD_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      send_q      <= '0;
      wait_q      <= '0;
      tally_q     <= '0;
      load_cnt_q  <= '0;
    end else begin
      mode_q      <= mode_d;
      saved_q     <= saved_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      cur_valid_q <= cur_valid_d;
      send_q      <= send_d;
      wait_q      <= wait_d;
      tally_q     <= tally_d;
      load_cnt_q  <= load_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cur_q  <= cur_d;
  end

  // queue store; read port follows the next head so rd_q tracks the head entry
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[tail_q] <= mem_wd;
    rd_q <= mem[head_d];
  end

  // results wait one stage in hold so the last flag is known when they leave
  assign cap     = (res_cnt_q == ResCntW'(MaxResults));
  assign emit_go = emit_v && !cap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      if ((emit_go || cmd_i.finish) && hold_v_q) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (emit_go) begin
        hold_v_q  <= 1'b1;
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (cmd_i.finish) begin
        hold_v_q  <= 1'b0;
        res_cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((emit_go || cmd_i.finish) && hold_v_q) begin
      out_q <= '{action: hold_q.action, result_cmd_id: hold_q.result_cmd_id,
                 completion: hold_q.completion, last: cmd_i.finish};
    end
    if (emit_go) hold_q <= emit_r;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign stat_o.is_tick    = (op == OP_TICK);
  assign stat_o.is_init    = (op == OP_INIT);
  assign stat_o.mode_idle  = (mode_q == MD_IDLE);
  assign stat_o.tally_over = (tally_q > error_limit_q);
  assign stat_o.queue_nz   = (count_q != '0);
  assign stat_o.load_last  = (load_cnt_q == BuiltinLast);
  assign stat_o.fin_ok     = !hold_v_q || !out_v_q || out_ready_i;
  assign stat_o.emit_ok    = cap || stat_o.fin_ok;

endmodule

// ----- sv/at_command_host_sequencer.sv -----
// Top level of the AT command host sequencer.
// Depends on atcs_pkg, atcs_ctrl and atcs_dp.
//
// Usage: each input transaction is one event (tick, submit, ok, error,
// prompt, busy, ready, report, init). Each event yields zero to ten result
// transactions on the output channel; the last one carries last = 1.
// Items are taken one at a time. A simple event passes through the
// accept, execute and close states before the next acceptance; a
// dispatching tick adds a dispatch state. Init, or a tick in idle with
// too many errors, walks the queue one entry per cycle while the output
// can take results, sees it empty, then sends the module reset and
// reloads the three built-in commands; a tick then also dispatches. A
// single output register and a one-deep hold stage carry results; when the
// receiver stalls, the sequencer waits at the next result and the input
// stays not ready. Configuration writes are always ready. After reset the
// controller is not ready, the queue is empty and the configuration
// registers hold their defaults.
`timescale 1ns / 1ps
module at_command_host_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  atcs_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output atcs_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [atcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [atcs_pkg::CfgDataW-1:0] cfg_data_i
);
  import atcs_pkg::*;

  seq_cmd_t  cmd;
  seq_stat_t stat;

  assign cfg_ready_o = 1'b1;

  atcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  atcs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // the sequencer issues at most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command");

  // closing an item frees the input
  a_finish_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> in_ready_o)
    else $error("input not ready after item closed");

  // a transaction is only taken in the cycle the input is ready
  a_take_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take_item |-> in_ready_o && in_valid_i)
    else $error("item latched without a transaction");

endmodule

// ----- sim/tb.sv -----
// Testbench of at_command_host_sequencer: random and directed events against a predictor.
// Depends on atcs_pkg and the RTL of the sequencer.
`timescale 1ns / 1ps
module tb;
  import atcs_pkg::*;

  localparam int unsigned Depth = 8;
  localparam int unsigned CycleLimit = 600000;

  // Predicts the result transactions of the sequencer and checks them in order.
  class seq_scoreboard;
    logic [15:0] busy_retry, reset_period, builtin_tmo;
    logic [7:0]  err_limit;
    mode_e       mode, saved_mode;
    entry_t      fifo [Depth];
    int unsigned head, tail, count;
    entry_t      cur;
    bit          cur_v;
    logic [15:0] send_el, wait_el;
    logic [7:0]  tally;
    out_t        pending_q[$];
    out_t        step_q[$];
    int unsigned errors;

    function new();
      busy_retry = BusyRetryRst; reset_period = ResetPeriodRst;
      err_limit = ErrorLimitRst; builtin_tmo = BuiltinTmoRst;
      mode = MD_NOT_READY; saved_mode = MD_IDLE;
      head = 0; tail = 0; count = 0; cur = '0; cur_v = 0;
      send_el = 0; wait_el = 0; tally = 0; errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_BUSY_RETRY:   busy_retry = v;
        CFG_RESET_PERIOD: reset_period = v;
        CFG_ERROR_LIMIT:  err_limit = v[7:0];
        CFG_BUILTIN_TMO:  builtin_tmo = v;
      endcase
    endfunction

    function void emit(act_e a, logic [7:0] id, done_e d);
      out_t r;
      if (step_q.size() >= MaxResults) return;
      r.action = a; r.result_cmd_id = id; r.completion = d; r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    function bit push_entry(entry_t e);
      if (count >= Depth) return 0;
      fifo[tail] = e; tail = (tail + 1) % Depth; count++;
      return 1;
    endfunction

    function entry_t pop_entry();
      entry_t e = fifo[head];
      head = (head + 1) % Depth; count--;
      return e;
    endfunction

    function void restart();
      entry_t e;
      while (count > 0) begin
        e = pop_entry();
        emit(ACT_COMPLETE, e.id, DONE_ERROR);
      end
      mode = MD_NOT_READY; head = 0; tail = 0; cur_v = 0; tally = 0;
      emit(ACT_SEND_RST, 8'd0, DONE_OK);
      wait_el = 0;
      for (int i = 0; i < 3; i++) begin
        e.id = 8'(i); e.data = 0; e.parser = 0; e.timeout = builtin_tmo;
        void'(push_entry(e));
      end
    endfunction

    function void finish_cmd(done_e d);
      if (cur_v) emit(ACT_COMPLETE, cur.id, d);
      cur_v = 0; mode = MD_IDLE;
    endfunction

    function void bump_tally();
      if (tally != TallyMax) tally++;
    endfunction

    function void ms_tick();
      if (send_el != TimerMax) send_el++;
      if (wait_el != TimerMax) wait_el++;
      case (mode)
        MD_IDLE: begin
          if (tally > err_limit) restart();
          if (count > 0) begin
            cur = pop_entry(); cur_v = 1;
            emit(ACT_SEND_CMD, cur.id, DONE_OK);
            send_el = 0;
            if (cur.data) begin
              mode = MD_WAIT_PROMPT; wait_el = 0;
            end else begin
              mode = MD_WAIT_RSP;
            end
          end
        end
        MD_BUSY: begin
          if (wait_el > busy_retry && cur_v) begin
            mode = cur.data ? MD_WAIT_PROMPT : saved_mode;
            emit(ACT_SEND_CMD, cur.id, DONE_OK);
          end
        end
        MD_WAIT_PROMPT, MD_WAIT_RSP: begin
          if (!cur_v) mode = MD_IDLE;
          else if (send_el > cur.timeout) finish_cmd(DONE_TIMEOUT);
        end
        MD_NOT_READY: begin
          if (wait_el > reset_period) begin
            emit(ACT_SEND_RST, 8'd0, DONE_OK);
            wait_el = 0;
          end
        end
        default: mode = MD_IDLE;
      endcase
    endfunction

    function void note_event(in_t x);
      entry_t e;
      step_q.delete();
      case (x.operation)
        OP_TICK: ms_tick();
        OP_SUBMIT: begin
          e.id = x.cmd_id; e.data = x.cmd_has_data;
          e.parser = x.cmd_has_parser; e.timeout = x.cmd_timeout_ms;
          emit(push_entry(e) ? ACT_ACCEPTED : ACT_REJECTED, x.cmd_id, DONE_OK);
        end
        OP_OK: if (mode == MD_WAIT_RSP) finish_cmd(DONE_OK);
        OP_ERROR: if (mode == MD_WAIT_RSP) begin
          finish_cmd(DONE_ERROR);
          bump_tally();
        end
        OP_PROMPT: begin
          if (mode == MD_WAIT_PROMPT && cur_v && cur.data) begin
            emit(ACT_SEND_DATA, cur.id, DONE_OK);
            mode = MD_WAIT_RSP;
          end else begin
            emit(ACT_SEND_ESC, cur_v ? cur.id : 8'd0, DONE_OK);
            bump_tally();
          end
        end
        OP_BUSY: if (cur_v) begin
          saved_mode = mode; mode = MD_BUSY; wait_el = 0;
        end
        OP_READY: mode = MD_IDLE;
        OP_REPORT: if (cur_v && cur.parser) emit(ACT_FORWARD, cur.id, DONE_OK);
        OP_INIT: restart();
        default: ;
      endcase
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.action !== want.action || got.result_cmd_id !== want.result_cmd_id ||
          got.completion !== want.completion || got.last !== want.last) begin
        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  seq_scoreboard sb = new();
  bit quiet = 0;
  bit hold_go = 0;
  bit hold_done = 0;

  at_command_host_sequencer #(.QUEUE_DEPTH(Depth)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_event(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver: random stalls per transaction, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_go && !hold_done) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end
      n = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_event(in_t x);
    int gap;
    gap = (quiet || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_op(op_e op, logic [7:0] id = 0, bit dat = 0, bit par = 0,
                         logic [15:0] tmo = 16'd1);
    in_t x;
    x.operation = op; x.cmd_id = id; x.cmd_has_data = dat;
    x.cmd_has_parser = par; x.cmd_timeout_ms = tmo;
    send_event(x);
  endtask

  // waits until every result arrived and any trailing work has ended
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] br, logic [15:0] rp, logic [7:0] el,
                            logic [15:0] bt);
    logic [15:0] vals [4];
    vals[0] = br; vals[1] = rp; vals[2] = {8'd0, el}; vals[3] = bt;
    cfg_valid <= 1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= CfgIdxW'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_valid <= 0;
  endtask

  function automatic in_t rand_event();
    in_t x;
    int w;
    w = $urandom_range(0, 99);
    x.cmd_id = 8'($urandom_range(0, 255));
    x.cmd_has_data = 1'($urandom_range(0, 1));
    x.cmd_has_parser = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: x.cmd_timeout_ms = 16'($urandom_range(1, 65535));
      1: x.cmd_timeout_ms = 16'hFFFF;
      default: x.cmd_timeout_ms = 16'($urandom_range(1, 25));
    endcase
    if (w < 38) x.operation = OP_TICK;
    else if (w < 58) x.operation = OP_SUBMIT;
    else if (w < 68) x.operation = OP_OK;
    else if (w < 73) x.operation = OP_ERROR;
    else if (w < 81) x.operation = OP_PROMPT;
    else if (w < 86) x.operation = OP_BUSY;
    else if (w < 91) x.operation = OP_REPORT;
    else if (w < 95) x.operation = OP_READY;
    else if (w < 97) x.operation = OP_INIT;
    else x.operation = 4'($urandom_range(9, 15));
    return x;
  endfunction

  task automatic random_phase(int n);
    send_op(OP_READY);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && !quiet) hold_go = 1;
      send_event(rand_event());
    end
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, each operation and the corner cases
    quiet = 1;
    send_op(OP_TICK);
    send_op(OP_BUSY);
    send_op(OP_READY);
    send_op(OP_SUBMIT, 8'hFF, 1, 1, 16'hFFFF);
    send_op(OP_SUBMIT, 8'h00, 0, 0, 16'd1);
    send_op(OP_TICK);
    send_op(OP_REPORT);
    send_op(OP_PROMPT);
    send_op(OP_OK);
    send_op(OP_TICK);
    send_op(OP_TICK);
    send_op(OP_TICK);
    send_op(OP_PROMPT);
    send_op(OP_ERROR);
    send_op(OP_OK);
    for (int i = 0; i < 9; i++) send_op(OP_SUBMIT, 8'(i * 29), i[0], i[1], 16'd5);
    send_op(op_e'(4'd15));
    send_op(OP_INIT);
    settle();

    write_regs(16'd1, 16'd1, 8'd0, 16'd1);
    random_phase(110);
    quiet = 0;
    write_regs(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    random_phase(110);
    write_regs(16'($urandom_range(1, 8)), 16'($urandom_range(1, 30)),
               8'($urandom_range(0, 4)), 16'($urandom_range(1, 20)));
    random_phase(110);
    write_regs(BusyRetryRst, 16'd5, 8'd2, 16'd12);
    random_phase(80);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- at_command_host_sequencer.f -----
sv/atcs_pkg.sv
sv/atcs_ctrl.sv
sv/atcs_dp.sv
sv/at_command_host_sequencer.sv
sim/tb.sv
